// ----- rtl/pcb_pkg.sv -----
// ----------------------------------------------------------------------------
// pcb_pkg: shared types and constants of the polyline corner bevel block
// Fixed-point widths, sequencer states and the square-root/divide unit request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcb_pkg;

  // default vertex store depth
  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned MIN_CORNERS    = 3;

  // fixed point
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned E_W       = 31;              // scaled edge component, below 2^30
  localparam int unsigned U_W       = FRAC_BITS + 2;   // unit component, magnitude up to one
  localparam int unsigned OFF_W     = 40;              // offset, saturated to 2^38 - 1
  localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'((64'd1 << 38) - 64'd1);

  // shared multiplier
  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_B_W = OFF_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned PT_W    = 42;

  // square root / divide unit
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned NUM_W  = COORD_W + FRAC_BITS;
  localparam int unsigned RES_W  = NUM_W;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  // register indexes (address bit 2)
  localparam logic REG_IDX_CLOSED = 1'b0;
  localparam logic REG_IDX_WIDTH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_PRV,
    ST_RD_NXT,
    ST_RD_LAST,
    ST_NORM,
    ST_SQ,
    ST_LEN,
    ST_UDIV,
    ST_DOT,
    ST_QCHK,
    ST_ROOT,
    ST_OFF,
    ST_PT,
    ST_OUT
  } pcb_state_e;

  typedef enum logic [1:0] {
    SDU_SQRT,
    SDU_DIV_UNIT,
    SDU_DIV_FULL
  } sdu_op_e;

  typedef struct packed {
    logic    start;
    sdu_op_e op;
  } sdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sdu_sts_t;

endpackage

// ----- rtl/pcb_ram.sv -----
// ----------------------------------------------------------------------------
// pcb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pcb_sdu.sv -----
// ----------------------------------------------------------------------------
// pcb_sdu: shared square-root / divide unit
// Restoring digit recurrence: one root or quotient bit per cycle on one
// compare-subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcb_sdu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcb_pkg::sdu_req_t              req_i,
  input  logic [pcb_pkg::RAD_W-1:0]      opnd_i,
  input  logic [pcb_pkg::DEN_W-1:0]      den_i,
  output pcb_pkg::sdu_sts_t              sts_o,
  output logic [pcb_pkg::RES_W-1:0]      res_o
);

  localparam int unsigned RAD_W  = pcb_pkg::RAD_W;
  localparam int unsigned REM_W  = pcb_pkg::REM_W;
  localparam int unsigned RES_W  = pcb_pkg::RES_W;
  localparam int unsigned DEN_W  = pcb_pkg::DEN_W;
  localparam int unsigned STEP_W = pcb_pkg::STEP_W;
  localparam int unsigned SHORT  = pcb_pkg::FRAC_BITS + 1;

  logic              busy_q, done_q, sqrt_q;
  logic [STEP_W-1:0] steps_q;
  logic [RAD_W-1:0]  opd_q, opd_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RES_W-1:0]  res_q, res_d;
  logic [DEN_W-1:0]  den_q;
  logic              ge;

  // one recurrence step
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[REM_W-3:0], opd_q[RAD_W-1 -: 2]};
      trial  = {res_q[REM_W-3:0], 2'b01};
      opd_d  = opd_q << 2;
    end else begin
      rem_sh = {rem_q[REM_W-2:0], opd_q[RAD_W-1]};
      trial  = REM_W'(den_q);
      opd_d  = opd_q << 1;
    end
    ge    = (rem_sh >= trial);
    rem_d = ge ? (rem_sh - trial) : rem_sh;
    res_d = {res_q[RES_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        unique case (req_i.op)
          pcb_pkg::SDU_SQRT:     steps_q <= STEP_W'(RAD_W / 2);
          pcb_pkg::SDU_DIV_UNIT: steps_q <= STEP_W'(SHORT);
          default:               steps_q <= STEP_W'(pcb_pkg::NUM_W);
        endcase
      end else if (busy_q) begin
        steps_q <= steps_q - STEP_W'(1);
        if (steps_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      res_q  <= '0;
      den_q  <= den_i;
      sqrt_q <= (req_i.op == pcb_pkg::SDU_SQRT);
      unique case (req_i.op)
        pcb_pkg::SDU_SQRT: begin
          rem_q <= '0;
          opd_q <= opnd_i;
        end
        pcb_pkg::SDU_DIV_UNIT: begin
          // quotient known below 2^SHORT: preload the high part
          rem_q <= REM_W'(opnd_i >> SHORT);
          opd_q <= opnd_i << (RAD_W - SHORT);
        end
        default: begin
          rem_q <= '0;
          opd_q <= opnd_i << (RAD_W - pcb_pkg::NUM_W);
        end
      endcase
    end else if (busy_q) begin
      rem_q <= rem_d;
      res_q <= res_d;
      opd_q <= opd_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = res_q;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("sdu started while busy");
`endif

endmodule

// ----- rtl/polyline_corner_bevel_core.sv -----
// ----------------------------------------------------------------------------
// polyline_corner_bevel_core: bevels the corners of a stored polyline
// Vertex store in RAM, a small sequencer, one multiplier and one shared
// square-root/divide unit.
// ----------------------------------------------------------------------------
// A load item (func 0) stores one vertex and completes in its accept cycle;
// busy stays low. An emit item (func 1) walks the next stored vertex: a
// passed-through or copied vertex gives one point after the states RD_CUR
// and RD_PRV, a corner gives two points. The corner time is set by the
// shared square-root/divide unit, which produces one bit per cycle: two
// 32-step roots for the edge lengths, six 17-step divides for the unit
// directions, one 32-step root and one 48-step divide for the offset. busy
// is high for the whole emit item, and results appear on valid_o for exactly
// one cycle each; the receiver cannot stall, so every result must be taken
// in the cycle it is shown. An emit with no vertex left produces nothing.
// Configuration must be written over the APB port while idle; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyline_corner_bevel_core #(
  parameter int unsigned MAX_POINTS = pcb_pkg::MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic        start_new_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  // results
  output logic        valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        last_of_item_o,
  output logic        end_of_curve_o,
  output logic        degenerate_o
);

  localparam int unsigned CW      = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW      = $clog2(MAX_POINTS);
  localparam int unsigned F       = pcb_pkg::FRAC_BITS;
  localparam int unsigned COORD_W = pcb_pkg::COORD_W;
  localparam int unsigned DIFF_W  = pcb_pkg::DIFF_W;
  localparam int unsigned E_W     = pcb_pkg::E_W;
  localparam int unsigned U_W     = pcb_pkg::U_W;
  localparam int unsigned OFF_W   = pcb_pkg::OFF_W;
  localparam int unsigned MUL_A_W = pcb_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W = pcb_pkg::MUL_B_W;
  localparam int unsigned PROD_W  = pcb_pkg::PROD_W;
  localparam int unsigned ACC_W   = pcb_pkg::ACC_W;
  localparam int unsigned PT_W    = pcb_pkg::PT_W;
  localparam int unsigned RAD_W   = pcb_pkg::RAD_W;
  localparam int unsigned NUM_W   = pcb_pkg::NUM_W;
  localparam int unsigned DEN_W   = pcb_pkg::DEN_W;
  localparam logic [1:0]  LANE_LAST = 2'd2;
  localparam logic [1:0]  IDX_LAST  = 2'd3;

  // saturate to 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] hi, lo;
    hi = PT_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = PT_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > hi)      sat32 = hi[COORD_W-1:0];
    else if (v < lo) sat32 = lo[COORD_W-1:0];
    else             sat32 = v[COORD_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  pcb_pkg::pcb_state_e state_q, state_d;

  logic                      closed_q;
  logic signed [31:0]        bevel_q;
  logic [CW-1:0]             cnt_q, cursor_q, c_q;
  logic                      end_q;
  logic [1:0]                idx_q;
  logic                      edge_q, issued_q;

  logic signed [COORD_W-1:0] cur_q [3];
  logic signed [COORD_W-1:0] prv_q [3];
  logic signed [COORD_W-1:0] nxt_q [3];
  logic signed [E_W-1:0]     e_q   [3];
  logic signed [U_W-1:0]     u_q   [2][3];
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [DEN_W-1:0]          len_q, root_q;
  logic [RAD_W-1:0]          rad_q;
  logic signed [OFF_W-1:0]   off_q;

  logic signed [COORD_W-1:0] out_q [3];
  logic                      out_last_q, out_end_q, out_deg_q;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic go, load, emit_go, cfg_wr;

  assign busy    = (state_q != pcb_pkg::ST_IDLE);
  assign go      = start & ~busy;
  assign load    = go & ~func_i;
  assign emit_go = go & func_i & (cursor_q < cnt_q);
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (paddr[2] == pcb_pkg::REG_IDX_WIDTH) ? bevel_q : {31'd0, closed_q};

  // --------------------------------------------------------------------------
  // vertex store, one word holds x, y and z
  // --------------------------------------------------------------------------
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [3*COORD_W-1:0] ram_rdata;
  logic [CW-1:0]        ip_idx, inx_idx;
  logic signed [COORD_W-1:0] rd_v [3];

  assign ram_we    = load & (start_new_i | (cnt_q < CW'(MAX_POINTS)));
  assign ram_waddr = start_new_i ? '0 : cnt_q[AW-1:0];

  // neighbours wrap at both ends
  assign ip_idx  = (c_q == '0) ? (cnt_q - CW'(1)) : (c_q - CW'(1));
  assign inx_idx = end_q ? '0 : (c_q + CW'(1));

  always_comb begin
    unique case (state_q)
      pcb_pkg::ST_RD_PRV: ram_raddr = ip_idx[AW-1:0];
      pcb_pkg::ST_RD_NXT: ram_raddr = inx_idx[AW-1:0];
      default:            ram_raddr = c_q[AW-1:0];
    endcase
  end

  pcb_ram #(
    .WIDTH(3 * COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_z_i, in_y_i, in_x_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_v[0] = ram_rdata[COORD_W-1:0];
  assign rd_v[1] = ram_rdata[2*COORD_W-1:COORD_W];
  assign rd_v[2] = ram_rdata[3*COORD_W-1:2*COORD_W];

  // copy or open-curve end point
  logic pass_c;
  assign pass_c = (cnt_q < CW'(pcb_pkg::MIN_CORNERS))
                | (~closed_q & ((c_q == '0) | end_q));

  // --------------------------------------------------------------------------
  // edge normalization: scale so every component stays below 2^30
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] d_c  [3];
  logic [DIFF_W-1:0]        ad_c [3];
  logic [DIFF_W-1:0]        m_c;
  logic [1:0]               s_c;
  logic signed [E_W-1:0]    e_c  [3];
  logic                     zero_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = (edge_q ? DIFF_W'(nxt_q[i]) : DIFF_W'(prv_q[i])) - DIFF_W'(cur_q[i]);
      ad_c[i] = d_c[i][DIFF_W-1] ? DIFF_W'(-d_c[i]) : DIFF_W'(d_c[i]);
    end
    m_c = ad_c[0];
    if (ad_c[1] > m_c) m_c = ad_c[1];
    if (ad_c[2] > m_c) m_c = ad_c[2];
    zero_c = (m_c == '0);
    priority if (m_c[32]) s_c = 2'd3;
    else if (m_c[31])     s_c = 2'd2;
    else if (m_c[30])     s_c = 2'd1;
    else                  s_c = 2'd0;
    for (int i = 0; i < 3; i++) begin
      e_c[i] = d_c[i][DIFF_W-1] ? -$signed(E_W'(ad_c[i] >> s_c))
                                :  $signed(E_W'(ad_c[i] >> s_c));
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier, product registered
  // --------------------------------------------------------------------------
  logic [1:0]                 lane, wlane;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;

  assign lane  = (idx_q == IDX_LAST) ? 2'd0 : idx_q;
  assign wlane = idx_q - 2'd1;

  always_comb begin
    unique case (state_q)
      pcb_pkg::ST_DOT: begin
        mul_a = MUL_A_W'(u_q[0][lane]);
        mul_b = MUL_B_W'(u_q[1][lane]);
      end
      pcb_pkg::ST_PT: begin
        mul_a = MUL_A_W'(u_q[edge_q][lane]);
        mul_b = off_q;
      end
      default: begin
        mul_a = MUL_A_W'(e_q[lane]);
        mul_b = MUL_B_W'(e_q[lane]);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // point: cur + trunc(u * off / one), saturated
  logic                     pneg;
  logic [PROD_W-1:0]        pmag;
  logic signed [PT_W-1:0]   ptrunc;
  logic signed [COORD_W-1:0] pt_c;

  always_comb begin
    pneg   = prod_q[PROD_W-1];
    pmag   = pneg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    ptrunc = pneg ? -$signed(PT_W'(pmag >> F)) : $signed(PT_W'(pmag >> F));
    pt_c   = sat32(PT_W'(cur_q[wlane]) + ptrunc);
  end

  // dot product and q = 2 * (one - dot)
  logic                    aneg, q_le0;
  logic [ACC_W-1:0]        amag;
  logic signed [ACC_W-1:0] dot_c, q_c;

  always_comb begin
    aneg  = acc_q[ACC_W-1];
    amag  = aneg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    dot_c = aneg ? -$signed(amag >> F) : $signed(amag >> F);
    q_c   = (($signed(ACC_W'(1)) <<< F) - dot_c) <<< 1;
    q_le0 = q_c[ACC_W-1] | (q_c == '0);
  end

  // --------------------------------------------------------------------------
  // square root / divide unit
  // --------------------------------------------------------------------------
  pcb_pkg::sdu_req_t sdu_req;
  pcb_pkg::sdu_sts_t sdu_sts;
  logic [RAD_W-1:0]  sdu_opnd;
  logic [DEN_W-1:0]  sdu_den;
  logic [pcb_pkg::RES_W-1:0] sdu_res;
  logic [E_W-2:0]    emag;
  logic [31:0]       bmag;
  logic              sdu_wait;

  assign emag = e_q[lane][E_W-1] ? (E_W-1)'(-e_q[lane]) : (E_W-1)'(e_q[lane]);
  assign bmag = bevel_q[31] ? 32'(-bevel_q) : 32'(bevel_q);

  assign sdu_wait = (state_q == pcb_pkg::ST_LEN) | (state_q == pcb_pkg::ST_UDIV)
                  | (state_q == pcb_pkg::ST_ROOT) | (state_q == pcb_pkg::ST_OFF);

  always_comb begin
    sdu_req.start = sdu_wait & ~issued_q;
    unique case (state_q)
      pcb_pkg::ST_UDIV: begin
        sdu_req.op = pcb_pkg::SDU_DIV_UNIT;
        sdu_opnd   = RAD_W'(emag) << F;
        sdu_den    = len_q;
      end
      pcb_pkg::ST_ROOT: begin
        sdu_req.op = pcb_pkg::SDU_SQRT;
        sdu_opnd   = rad_q;
        sdu_den    = root_q;
      end
      pcb_pkg::ST_OFF: begin
        sdu_req.op = pcb_pkg::SDU_DIV_FULL;
        sdu_opnd   = RAD_W'(bmag) << F;
        sdu_den    = root_q;
      end
      default: begin
        sdu_req.op = pcb_pkg::SDU_SQRT;
        sdu_opnd   = acc_q;
        sdu_den    = len_q;
      end
    endcase
  end

  pcb_sdu u_sdu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sdu_req),
    .opnd_i(sdu_opnd),
    .den_i (sdu_den),
    .sts_o (sdu_sts),
    .res_o (sdu_res)
  );

  // unit direction component with sign of e
  logic signed [U_W-1:0] u_c;
  assign u_c = e_q[lane][E_W-1] ? -$signed(sdu_res[U_W-1:0]) : $signed(sdu_res[U_W-1:0]);

  // offset saturated to +-(2^38 - 1)
  logic [OFF_W-1:0]        osat;
  logic signed [OFF_W-1:0] off_c;
  assign osat  = (sdu_res > NUM_W'(pcb_pkg::OFF_LIMIT)) ? pcb_pkg::OFF_LIMIT
                                                        : sdu_res[OFF_W-1:0];
  assign off_c = bevel_q[31] ? -$signed(osat) : $signed(osat);

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcb_pkg::ST_IDLE:    if (emit_go) state_d = pcb_pkg::ST_RD_CUR;
      pcb_pkg::ST_RD_CUR:  state_d = pcb_pkg::ST_RD_PRV;
      pcb_pkg::ST_RD_PRV:  state_d = pass_c ? pcb_pkg::ST_OUT : pcb_pkg::ST_RD_NXT;
      pcb_pkg::ST_RD_NXT:  state_d = pcb_pkg::ST_RD_LAST;
      pcb_pkg::ST_RD_LAST: state_d = pcb_pkg::ST_NORM;
      pcb_pkg::ST_NORM:    state_d = zero_c ? pcb_pkg::ST_OUT : pcb_pkg::ST_SQ;
      pcb_pkg::ST_SQ:      if (idx_q == IDX_LAST) state_d = pcb_pkg::ST_LEN;
      pcb_pkg::ST_LEN:     if (sdu_sts.done) state_d = pcb_pkg::ST_UDIV;
      pcb_pkg::ST_UDIV: begin
        if (sdu_sts.done && idx_q == LANE_LAST) begin
          state_d = edge_q ? pcb_pkg::ST_DOT : pcb_pkg::ST_NORM;
        end
      end
      pcb_pkg::ST_DOT:     if (idx_q == IDX_LAST) state_d = pcb_pkg::ST_QCHK;
      pcb_pkg::ST_QCHK:    state_d = q_le0 ? pcb_pkg::ST_OUT : pcb_pkg::ST_ROOT;
      pcb_pkg::ST_ROOT:    if (sdu_sts.done) state_d = pcb_pkg::ST_OFF;
      pcb_pkg::ST_OFF:     if (sdu_sts.done) state_d = pcb_pkg::ST_PT;
      pcb_pkg::ST_PT:      if (idx_q == IDX_LAST) state_d = pcb_pkg::ST_OUT;
      pcb_pkg::ST_OUT: begin
        priority if (out_last_q) state_d = pcb_pkg::ST_IDLE;
        else if (out_deg_q)      state_d = pcb_pkg::ST_OUT;
        else                     state_d = pcb_pkg::ST_PT;
      end
      default:             state_d = pcb_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    valid_o = (state_q == pcb_pkg::ST_OUT);
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcb_pkg::ST_IDLE;
      closed_q <= 1'b0;
      bevel_q  <= '0;
      cnt_q    <= '0;
      cursor_q <= '0;
      idx_q    <= '0;
      edge_q   <= 1'b0;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        if (paddr[2] == pcb_pkg::REG_IDX_WIDTH) bevel_q  <= pwdata;
        else                                    closed_q <= pwdata[0];
      end

      // store fill and walk position
      if (load) begin
        if (start_new_i) begin
          cnt_q    <= CW'(1);
          cursor_q <= '0;
        end else if (cnt_q < CW'(MAX_POINTS)) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (emit_go) cursor_q <= cursor_q + CW'(1);

      if (sdu_req.start)     issued_q <= 1'b1;
      else if (sdu_sts.done) issued_q <= 1'b0;

      unique case (state_q)
        pcb_pkg::ST_IDLE: begin
          idx_q  <= '0;
          edge_q <= 1'b0;
        end
        pcb_pkg::ST_NORM: idx_q <= '0;
        pcb_pkg::ST_SQ, pcb_pkg::ST_DOT, pcb_pkg::ST_PT: idx_q <= idx_q + 2'd1;
        pcb_pkg::ST_UDIV: begin
          if (sdu_sts.done) begin
            if (idx_q == LANE_LAST) begin
              idx_q  <= '0;
              edge_q <= ~edge_q;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        pcb_pkg::ST_OFF: begin
          idx_q  <= '0;
          edge_q <= 1'b0;
        end
        pcb_pkg::ST_OUT: begin
          // second corner point follows
          if (!out_last_q && !out_deg_q) begin
            idx_q  <= '0;
            edge_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pcb_pkg::ST_IDLE: begin
        if (emit_go) begin
          c_q   <= cursor_q;
          end_q <= (cursor_q == cnt_q - CW'(1));
        end
      end
      pcb_pkg::ST_RD_PRV: begin
        cur_q <= rd_v;
        if (pass_c) begin
          out_q      <= rd_v;
          out_last_q <= 1'b1;
          out_end_q  <= end_q;
          out_deg_q  <= 1'b0;
        end
      end
      pcb_pkg::ST_RD_NXT:  prv_q <= rd_v;
      pcb_pkg::ST_RD_LAST: nxt_q <= rd_v;
      pcb_pkg::ST_NORM: begin
        e_q   <= e_c;
        acc_q <= '0;
        if (zero_c) begin
          out_q      <= cur_q;
          out_last_q <= 1'b0;
          out_end_q  <= 1'b0;
          out_deg_q  <= 1'b1;
        end
      end
      pcb_pkg::ST_SQ, pcb_pkg::ST_DOT: begin
        if (idx_q != '0) acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
      end
      pcb_pkg::ST_LEN: begin
        if (sdu_sts.done) len_q <= sdu_res[DEN_W-1:0];
      end
      pcb_pkg::ST_UDIV: begin
        if (sdu_sts.done) begin
          u_q[edge_q][lane] <= u_c;
          if (idx_q == LANE_LAST) acc_q <= '0;
        end
      end
      pcb_pkg::ST_QCHK: begin
        rad_q <= RAD_W'(q_c) << F;
        if (q_le0) begin
          out_q      <= cur_q;
          out_last_q <= 1'b0;
          out_end_q  <= 1'b0;
          out_deg_q  <= 1'b1;
        end
      end
      pcb_pkg::ST_ROOT: begin
        if (sdu_sts.done) root_q <= sdu_res[DEN_W-1:0];
      end
      pcb_pkg::ST_OFF: begin
        if (sdu_sts.done) off_q <= off_c;
      end
      pcb_pkg::ST_PT: begin
        if (idx_q != '0) out_q[wlane] <= pt_c;
        if (idx_q == IDX_LAST) begin
          out_last_q <= edge_q;
          out_end_q  <= edge_q & end_q;
          out_deg_q  <= 1'b0;
        end
      end
      pcb_pkg::ST_OUT: begin
        // degenerate corner repeats cur as its closing point
        if (!out_last_q && out_deg_q) begin
          out_last_q <= 1'b1;
          out_end_q  <= end_q;
        end
      end
      default: ;
    endcase
  end

  assign out_x_o        = out_q[0];
  assign out_y_o        = out_q[1];
  assign out_z_o        = out_q[2];
  assign last_of_item_o = out_last_q;
  assign end_of_curve_o = out_end_q;
  assign degenerate_o   = out_deg_q;

`ifndef ASSERT_OFF
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= cnt_q)
    else $error("emit cursor beyond vertex count");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && end_of_curve_o |-> last_of_item_o)
    else $error("end of curve on a non-final point");

  a_deg_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o && !last_of_item_o |=>
      valid_o && degenerate_o && last_of_item_o)
    else $error("degenerate corner not closed by second point");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("vertex count beyond store depth");
`endif

endmodule
